// ----- src/afc_pkg.sv -----
// Shared types, codes and helpers for the APNG frame compositor.
// Used by every module of the compositor but afc_fifo; depends on nothing.
package afc_pkg;

  localparam int AFC_MAX_WIDTH  = 256;
  localparam int AFC_MAX_HEIGHT = 256;

  // Address of a canvas pixel before the store range check:
  // up to 510 * 256 + 510 with the default canvas limits, which needs 17 bits.
  localparam int ADDR_W  = 19;
  // Readout index and row counter; the index stays below 511 * 511.
  localparam int IDX_W   = 18;
  localparam int DIVD_W  = 26;
  localparam int DIVS_W  = 16;
  localparam int DIV_CNT_W = 5;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] FUNC_HDR   = 2'd0;
  localparam logic [1:0] FUNC_PIXEL = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  localparam logic [1:0] DISP_NONE = 2'd0;
  localparam logic [1:0] DISP_BG   = 2'd1;
  localparam logic [1:0] DISP_PREV = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_ORDER  = 2'd2;

  localparam logic [1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [1:0] REG_CANVAS_HEIGHT = 2'd1;

  localparam logic [8:0] CANVAS_DIM_RESET = 9'd256;
  localparam logic [15:0] DEN_DEFAULT     = 16'd100;
  localparam logic [DIVD_W-1:0] MS_PER_S  = 26'd1000;

  typedef enum logic [1:0] {
    OP_STAT = 2'd0,
    OP_HDR  = 2'd1,
    OP_PIX  = 2'd2,
    OP_RD   = 2'd3
  } op_t;

  // One classified item, handed from the front to the back.
  typedef struct packed {
    op_t               op;
    logic [1:0]        status;
    logic [ADDR_W-1:0] addr;
    logic              addr_ok;
    logic [31:0]       src;
    logic              blend;
    logic [1:0]        dispose;
    logic              in_rect;
    logic              last;
    logic [DIVD_W-1:0] dividend;
    logic [DIVS_W-1:0] divisor;
  } item_t;

  typedef struct packed {
    logic [31:0]       rgba;
    logic [DIVD_W-1:0] delay;
    logic [1:0]        status;
    logic              last;
  } res_t;

  // Exact v / 255 for v below 65280.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] t;
    t = 17'(v) + 17'(v >> 8) + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ----- src/afc_fifo.sv -----
// Small first-in first-out queue of registers.
// Generic in width and depth; uses no package items.
module afc_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slots [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full  = (32'(count) == DEPTH);
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (32'(wptr) == DEPTH - 1) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (32'(rptr) == DEPTH - 1) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH) else $error("fifo count above depth");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (do_wr && !do_rd) |=> count == $past(count) + 1'b1)
    else $error("fifo count did not grow on a lone write");
  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (do_rd && !do_wr) |=> count == $past(count) - 1'b1)
    else $error("fifo count did not shrink on a lone read");

endmodule

// ----- src/afc_front.sv -----
// Front of the compositor: configuration registers, phase tracking,
// address generation and premultiplication. Depends on afc_pkg.
module afc_front import afc_pkg::*; #(
  parameter int MAX_WIDTH  = AFC_MAX_WIDTH,
  parameter int MAX_HEIGHT = AFC_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        take,
  input  logic [1:0]  func,
  input  logic [8:0]  frame_width,
  input  logic [8:0]  frame_height,
  input  logic [7:0]  x_offset,
  input  logic [7:0]  y_offset,
  input  logic [1:0]  dispose_op,
  input  logic        blend_op,
  input  logic [15:0] delay_num,
  input  logic [15:0] delay_den,
  input  logic [31:0] pixel_rgba,
  output item_t       item
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

  logic [8:0]       cw_raw, ch_raw, cw, ch;
  logic [8:0]       hdr_w, hdr_h;
  logic [7:0]       hdr_x, hdr_y;
  logic [1:0]       hdr_dispose;
  logic             hdr_blend;
  logic [7:0]       fx, fy;
  logic [8:0]       rd_x;
  logic [IDX_W-1:0] rd_y, ridx;
  logic             header_valid, in_readout, first_pending;

  logic             is_hdr, is_pix, is_rd, bad;
  logic [8:0]       xpos, ypos, fx_inc, fy_inc;
  logic [9:0]       rx_inc;
  logic [IDX_W-1:0] prod, total;
  logic             rd_last;
  logic [31:0]      src;

  assign cfg_ready = 1'b1;

  assign cw = (cw_raw == 9'd0) ? 9'd1 :
              ((32'(cw_raw) > MAX_WIDTH) ? 9'(MAX_WIDTH) : cw_raw);
  assign ch = (ch_raw == 9'd0) ? 9'd1 :
              ((32'(ch_raw) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : ch_raw);

  assign is_hdr = (func == FUNC_HDR) && !header_valid;
  assign is_pix = (func == FUNC_PIXEL) && header_valid && !in_readout;
  assign is_rd  = (func == FUNC_READ) && header_valid && in_readout;
  assign bad    = (frame_width == 9'd0) || (frame_height == 9'd0) ||
                  (10'(x_offset) + 10'(frame_width) > 10'(cw)) ||
                  (10'(y_offset) + 10'(frame_height) > 10'(ch));

  assign xpos    = 9'(hdr_x) + 9'(fx);
  assign ypos    = 9'(hdr_y) + 9'(fy);
  assign prod    = IDX_W'(ypos) * IDX_W'(cw);
  assign fx_inc  = 9'(fx) + 9'd1;
  assign fy_inc  = 9'(fy) + 9'd1;
  assign rx_inc  = 10'(rd_x) + 10'd1;
  assign total   = IDX_W'(cw) * IDX_W'(ch);
  assign rd_last = (19'(ridx) + 19'd1) >= 19'(total);

  always_comb begin
    logic [7:0] al;
    al = pixel_rgba[31:24];
    src = {al, 24'd0};
    for (int i = 0; i < 3; i++) begin
      src[8*i +: 8] = div255(16'(pixel_rgba[8*i +: 8]) * 16'(al) + 16'd127);
    end
  end

  always_comb begin
    item          = '0;
    item.op       = OP_STAT;
    item.status   = ST_ORDER;
    item.blend    = hdr_blend;
    item.dispose  = hdr_dispose;
    if (is_hdr) begin
      if (bad) begin
        item.status = ST_BOUNDS;
      end else begin
        item.op       = OP_HDR;
        item.status   = ST_OK;
        item.dividend = DIVD_W'(delay_num) * MS_PER_S;
        item.divisor  = (delay_den == 16'd0) ? DEN_DEFAULT : delay_den;
      end
    end else if (is_pix) begin
      item.op      = OP_PIX;
      item.status  = ST_OK;
      item.addr    = ADDR_W'(prod) + ADDR_W'(xpos);
      item.addr_ok = 32'(item.addr) < DEPTH;
      item.src     = src;
    end else if (is_rd) begin
      item.op      = OP_RD;
      item.status  = ST_OK;
      item.addr    = ADDR_W'(ridx);
      item.addr_ok = 1'b1;
      item.in_rect = (10'(rd_x) >= 10'(hdr_x)) &&
                     (10'(rd_x) < 10'(hdr_x) + 10'(hdr_w)) &&
                     (rd_y >= IDX_W'(hdr_y)) &&
                     (rd_y < IDX_W'(hdr_y) + IDX_W'(hdr_h));
      item.last    = rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cw_raw        <= CANVAS_DIM_RESET;
      ch_raw        <= CANVAS_DIM_RESET;
      hdr_w         <= '0;
      hdr_h         <= '0;
      hdr_x         <= '0;
      hdr_y         <= '0;
      hdr_dispose   <= DISP_NONE;
      hdr_blend     <= 1'b0;
      fx            <= '0;
      fy            <= '0;
      rd_x          <= '0;
      rd_y          <= '0;
      ridx          <= '0;
      header_valid  <= 1'b0;
      in_readout    <= 1'b0;
      first_pending <= 1'b1;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CANVAS_WIDTH) begin
          cw_raw <= cfg_data;
        end else if (cfg_index == REG_CANVAS_HEIGHT) begin
          ch_raw <= cfg_data;
        end
      end
      if (take) begin
        if (is_hdr && !bad) begin
          hdr_w        <= frame_width;
          hdr_h        <= frame_height;
          hdr_x        <= x_offset;
          hdr_y        <= y_offset;
          fx           <= '0;
          fy           <= '0;
          header_valid <= 1'b1;
          in_readout   <= 1'b0;
          // The first displayed frame has nothing beneath it to blend or keep.
          if (first_pending) begin
            hdr_blend     <= 1'b0;
            hdr_dispose   <= (dispose_op == DISP_PREV) ? DISP_BG : dispose_op;
            first_pending <= 1'b0;
          end else begin
            hdr_blend   <= blend_op;
            hdr_dispose <= dispose_op;
          end
        end else if (is_pix) begin
          if (fx_inc >= hdr_w) begin
            fx <= '0;
            if (fy_inc >= hdr_h) begin
              in_readout <= 1'b1;
              ridx       <= '0;
              rd_x       <= '0;
              rd_y       <= '0;
            end else begin
              fy <= fy_inc[7:0];
            end
          end else begin
            fx <= fx_inc[7:0];
          end
        end else if (is_rd) begin
          if (rd_last) begin
            header_valid <= 1'b0;
            in_readout   <= 1'b0;
            ridx         <= '0;
            rd_x         <= '0;
            rd_y         <= '0;
          end else begin
            ridx <= ridx + 1'b1;
            if (rx_inc >= 10'(cw)) begin
              rd_x <= '0;
              rd_y <= rd_y + 1'b1;
            end else begin
              rd_x <= rx_inc[8:0];
            end
          end
        end
      end
    end
  end

endmodule

// ----- src/afc_div.sv -----
// Restoring divider, one quotient bit per cycle, for the frame delay.
// Depends on afc_pkg for the operand widths.
module afc_div import afc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVS_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIVS_W:0]      rem, shifted;
  logic [DIVS_W-1:0]    dvs;
  logic [DIVD_W-1:0]    quo;

  assign shifted  = {rem[DIVS_W-1:0], quo[DIVD_W-1]};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      if (shifted >= {1'b0, dvs}) begin
        rem <= shifted - {1'b0, dvs};
        quo <= {quo[DIVD_W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[DIVD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (32'(cnt) == DIVD_W - 1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/afc_back.sv -----
// Back of the compositor: canvas and saved stores, compositing, dispose,
// clearing pass and result assembly. Depends on afc_pkg and afc_div.
module afc_back import afc_pkg::*; #(
  parameter int MAX_WIDTH  = AFC_MAX_WIDTH,
  parameter int MAX_HEIGHT = AFC_MAX_HEIGHT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_empty,
  output logic  q_pop,
  input  item_t q_data,
  input  logic  out_full,
  output logic  out_wr,
  output res_t  out_data,
  output logic  clearing
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_RD   = 6'b000100,
    S_EXE  = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t            state;
  item_t             cur;
  res_t              res;
  logic [AW-1:0]     clr, ma;
  logic [31:0]       canvas [DEPTH];
  logic [31:0]       saved  [DEPTH];
  logic [31:0]       cdata, sdata, old, blended, cwd;
  logic              cwe, swe, div_start, div_done;
  logic [DIVD_W-1:0] quotient;

  assign ma        = AW'(cur.addr);
  assign clearing  = (state == S_CLR);
  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign div_start = q_pop && (q_data.op == OP_HDR);
  assign out_wr    = (state == S_DONE) && !out_full;
  assign out_data  = res;
  assign old       = cur.addr_ok ? cdata : 32'd0;

  afc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (q_data.dividend),
    .divisor  (q_data.divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Alpha OVER with per-channel saturation.
  always_comb begin
    logic [7:0] inv;
    logic [8:0] v;
    inv = 8'd255 - cur.src[31:24];
    blended = '0;
    for (int i = 0; i < 4; i++) begin
      v = 9'(cur.src[8*i +: 8]) +
          9'(div255(16'(old[8*i +: 8]) * 16'(inv) + 16'd127));
      blended[8*i +: 8] = v[8] ? 8'd255 : v[7:0];
    end
  end

  always_comb begin
    cwe = 1'b0;
    swe = 1'b0;
    cwd = '0;
    if (cur.op == OP_PIX) begin
      cwe = cur.addr_ok;
      swe = cur.addr_ok && (cur.dispose == DISP_PREV);
      cwd = cur.blend ? blended : cur.src;
    end else if (cur.op == OP_RD) begin
      cwe = cur.in_rect && ((cur.dispose == DISP_BG) || (cur.dispose == DISP_PREV));
      cwd = (cur.dispose == DISP_PREV) ? sdata : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      canvas[clr] <= '0;
      saved[clr]  <= '0;
    end else if (state == S_EXE) begin
      if (cwe) begin
        canvas[ma] <= cwd;
      end
      if (swe) begin
        saved[ma] <= cdata;
      end
    end
    if (state == S_RD) begin
      cdata <= canvas[ma];
      sdata <= saved[ma];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    case (state)
      S_IDLE: begin
        if (q_pop) begin
          res <= '{rgba: '0, delay: '0, status: q_data.status, last: 1'b0};
        end
      end
      S_EXE: begin
        if (cur.op == OP_RD) begin
          res.rgba <= cdata;
          res.last <= cur.last;
        end
      end
      S_DIV: begin
        if (div_done) begin
          res.delay <= quotient;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr   <= '0;
    end else begin
      case (state)
        S_CLR: begin
          clr <= clr + 1'b1;
          if (32'(clr) == DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (q_pop) begin
            case (q_data.op)
              OP_HDR:  state <= S_DIV;
              OP_PIX:  state <= S_RD;
              OP_RD:   state <= S_RD;
              default: state <= S_DONE;
            endcase
          end
        end
        S_RD:  state <= S_EXE;
        S_EXE: state <= S_DONE;
        S_DIV: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_CLR;
      endcase
    end
  end

endmodule

// ----- src/apng_frame_compositor_core.sv -----
// APNG frame compositor, top level. The back handles a pixel or readout item
// in steps (pop, store read, composite or dispose, result); a frame header
// waits instead on the one-bit-per-cycle delay divider for its 26 quotient
// bits. After reset, full stays high while both stores are cleared. Depends
// on afc_pkg, afc_front, afc_fifo and afc_back.
module apng_frame_compositor_core import afc_pkg::*; #(
  parameter int MAX_WIDTH  = AFC_MAX_WIDTH,
  parameter int MAX_HEIGHT = AFC_MAX_HEIGHT
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  // Input side, seen as a queue.
  input  logic        push,
  output logic        full,
  input  logic [1:0]  func,
  input  logic [8:0]  frame_width,
  input  logic [8:0]  frame_height,
  input  logic [7:0]  x_offset,
  input  logic [7:0]  y_offset,
  input  logic [1:0]  dispose_op,
  input  logic        blend_op,
  input  logic [15:0] delay_num,
  input  logic [15:0] delay_den,
  input  logic [31:0] pixel_rgba,
  // Result side, seen as a queue.
  output logic        empty,
  input  logic        pop,
  output logic [31:0] canvas_rgba,
  output logic [25:0] delay_ms,
  output logic [1:0]  status,
  output logic        last
);

  // The front classifies each item against the frame phase, computes its
  // canvas address and premultiplies pixels in the cycle of the transfer.
  // Classified items wait in a short queue, so the front keeps accepting
  // while the back is busy with a store access or a delay division.
  // Results go through a second queue, so a stalled consumer does not stop
  // the back until that queue fills.

  item_t front_item, back_item;
  res_t  back_res, head_res;
  logic  q_full, q_empty, q_pop;
  logic  out_full, out_wr;
  logic  clearing, take;

  // No item is taken while the stores are being cleared after reset.
  assign full = q_full || clearing;
  assign take = push && !full;

  afc_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .take         (take),
    .func         (func),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .x_offset     (x_offset),
    .y_offset     (y_offset),
    .dispose_op   (dispose_op),
    .blend_op     (blend_op),
    .delay_num    (delay_num),
    .delay_den    (delay_den),
    .pixel_rgba   (pixel_rgba),
    .item         (front_item)
  );

  afc_fifo #(
    .W     ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (take),
    .wdata (front_item),
    .full  (q_full),
    .rd    (q_pop),
    .rdata (back_item),
    .empty (q_empty)
  );

  // The back runs one item at a time, so every store read sees the writes
  // of all earlier items.
  afc_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .q_data   (back_item),
    .out_full (out_full),
    .out_wr   (out_wr),
    .out_data (back_res),
    .clearing (clearing)
  );

  afc_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .wr    (out_wr),
    .wdata (back_res),
    .full  (out_full),
    .rd    (pop),
    .rdata (head_res),
    .empty (empty)
  );

  // The oldest result sits on the ports while empty is low.
  assign canvas_rgba = head_res.rgba;
  assign delay_ms    = head_res.delay;
  assign status      = head_res.status;
  assign last        = head_res.last;

endmodule
